FILE: hdl/tmp_pkg.sv
package tmp_pkg;

    // Request codes carried on s_req_type.
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_SET_DEF = 2'd1,
        REQ_SET_LIM = 2'd2,
        REQ_STOP    = 2'd3
    } req_t;

    // Move phases reported on m_move_phase.
    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TICK_PERIOD = 2'd0,
        CFG_VEL_MAX     = 2'd1,
        CFG_ACC_MAX     = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_ADT,
        ST_TICK_VEL,
        ST_TICK_MAG,
        ST_TICK_POS,
        ST_TIME_VV,
        ST_TIME_SA,
        ST_TIME_CMP,
        ST_TIME_SEL,
        ST_SQRT,
        ST_DIV,
        ST_DIV_DONE,
        ST_OUT
    } state_t;

    // Which quotient the shared divider is producing.
    typedef enum logic [1:0] {
        DV_RAMP,
        DV_VA,
        DV_SV,
        DV_TRI
    } div_tag_t;

    localparam logic [31:0] TICK_PERIOD_RST = 32'd4294967;
    localparam logic [30:0] VEL_MAX_RST     = 31'd65536;
    localparam logic [30:0] ACC_MAX_RST     = 31'd65536;
    localparam logic [31:0] TIME_SAT        = 32'hFFFF_FFFF;

endpackage

FILE: hdl/trapezoid_motion_profile.sv
// Channel   | Direction | Handshake          | Contents
// ----------+-----------+--------------------+---------------------------------------------
// s_*       | in        | s_valid / s_ready  | one request: tick, set target, stop, query
// m_*       | out       | m_valid / m_ready  | reference state and time figures per request
// cfg_*     | in        | cfg_we             | tick period and default limits
//
// The block works on one request at a time and holds s_ready low from acceptance
// until its result has been taken. A tick steps through ST_TICK_ADT, ST_TICK_VEL,
// ST_TICK_MAG and ST_TICK_POS while a move is unfinished. Planning a move runs one
// 32x32 multiplier and a shared radix-2 divider or a bit-serial square root: a
// trapezoidal plan takes three quotients, a triangular one a root and a quotient.
// A time query takes two quotients if trapezoidal, a root and a quotient if triangular.
// Reset (aresetn low at a clock edge) clears all profile state and loads the
// register defaults. A stalled result simply holds in place until m_ready.
module trapezoid_motion_profile (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [31:0] s_pos_start,
    input  logic signed [31:0] s_pos_final,
    input  logic [30:0]        s_vel_limit,
    input  logic [30:0]        s_acc_limit,
    input  logic signed [31:0] s_pos_actual,
    input  logic signed [31:0] s_move_delta,
    input  logic               s_query_time,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_ref,
    output logic signed [31:0] m_vel_ref,
    output logic signed [31:0] m_acc_ref,
    output logic [1:0]         m_move_phase,
    output logic               m_moving,
    output logic               m_triangular,
    output logic [31:0]        m_move_time,
    output logic [31:0]        m_time_estimate
);

    // Configuration registers.
    logic [31:0] tick_reg;
    logic [30:0] dvel_reg;
    logic [30:0] dacc_reg;

    // Sequencer and profile state.
    tmp_pkg::state_t   state_reg, state_next;
    tmp_pkg::phase_t   phase_reg, phase_next;
    logic signed [31:0] start_pos_reg, start_pos_next;
    logic signed [31:0] final_pos_reg, final_pos_next;
    logic signed [31:0] ref_pos_reg, ref_pos_next;
    logic signed [31:0] ref_vel_reg, ref_vel_next;
    logic signed [31:0] ref_acc_reg, ref_acc_next;
    logic               dir_neg_reg, dir_neg_next;
    logic               active_reg, active_next;
    logic               tri_reg, tri_next;
    logic [32:0]        stroke_reg, stroke_next;
    logic [30:0]        cruise_reg, cruise_next;
    logic [30:0]        used_acc_reg, used_acc_next;
    logic [32:0]        ramp_reg, ramp_next;
    logic [31:0]        ptime_reg, ptime_next;
    logic [31:0]        est_reg, est_next;

    // Work registers of the current request; they need no reset.
    logic               query_reg, query_next;
    logic signed [31:0] md_reg, md_next;
    logic signed [31:0] act_reg, act_next;
    logic               is_plan_reg, is_plan_next;
    logic [32:0]        w_s_reg, w_s_next;
    logic [30:0]        w_v_reg, w_v_next;
    logic [30:0]        w_a_reg, w_a_next;
    logic [63:0]        prod_reg, prod_next;
    logic [61:0]        vv_reg, vv_next;
    logic [63:0]        sa_reg, sa_next;
    logic [47:0]        t1_reg, t1_next;
    logic [63:0]        div_q_reg, div_q_next;
    logic [31:0]        div_r_reg, div_r_next;
    logic [31:0]        div_d_reg, div_d_next;
    logic [5:0]         div_cnt_reg, div_cnt_next;
    tmp_pkg::div_tag_t  div_tag_reg, div_tag_next;
    logic [63:0]        sq_x_reg, sq_x_next;
    logic [63:0]        sq_r_reg, sq_r_next;
    logic [63:0]        sq_bit_reg, sq_bit_next;

    // The one shared multiplier; its operands are picked by the sequencer state.
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    assign mul_p = mul_a * mul_b;

    assign s_ready         = (state_reg == tmp_pkg::ST_IDLE);
    assign m_valid         = (state_reg == tmp_pkg::ST_OUT);
    assign m_pos_ref       = ref_pos_reg;
    assign m_vel_ref       = ref_vel_reg;
    assign m_acc_ref       = ref_acc_reg;
    assign m_move_phase    = phase_reg;
    assign m_moving        = active_reg;
    assign m_triangular    = tri_reg;
    assign m_move_time     = ptime_reg;
    assign m_time_estimate = est_reg;

    // Configuration writes land at once; user must write only while idle, unenforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= tmp_pkg::TICK_PERIOD_RST;
            dvel_reg <= tmp_pkg::VEL_MAX_RST;
            dacc_reg <= tmp_pkg::ACC_MAX_RST;
        end else if (cfg_we) begin
            case (tmp_pkg::cfg_idx_t'(cfg_addr))
                tmp_pkg::CFG_TICK_PERIOD: tick_reg <= cfg_wdata;
                tmp_pkg::CFG_VEL_MAX:     dvel_reg <= cfg_wdata[30:0];
                tmp_pkg::CFG_ACC_MAX:     dacc_reg <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tmp_pkg::ST_IDLE;
            phase_reg     <= tmp_pkg::PH_ACCEL;
            start_pos_reg <= '0;
            final_pos_reg <= '0;
            ref_pos_reg   <= '0;
            ref_vel_reg   <= '0;
            ref_acc_reg   <= '0;
            dir_neg_reg   <= 1'b0;
            active_reg    <= 1'b0;
            tri_reg       <= 1'b0;
            stroke_reg    <= '0;
            cruise_reg    <= '0;
            used_acc_reg  <= '0;
            ramp_reg      <= '0;
            ptime_reg     <= '0;
            est_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            start_pos_reg <= start_pos_next;
            final_pos_reg <= final_pos_next;
            ref_pos_reg   <= ref_pos_next;
            ref_vel_reg   <= ref_vel_next;
            ref_acc_reg   <= ref_acc_next;
            dir_neg_reg   <= dir_neg_next;
            active_reg    <= active_next;
            tri_reg       <= tri_next;
            stroke_reg    <= stroke_next;
            cruise_reg    <= cruise_next;
            used_acc_reg  <= used_acc_next;
            ramp_reg      <= ramp_next;
            ptime_reg     <= ptime_next;
            est_reg       <= est_next;
        end
    end

    always_ff @(posedge aclk) begin
        query_reg   <= query_next;
        md_reg      <= md_next;
        act_reg     <= act_next;
        is_plan_reg <= is_plan_next;
        w_s_reg     <= w_s_next;
        w_v_reg     <= w_v_next;
        w_a_reg     <= w_a_next;
        prod_reg    <= prod_next;
        vv_reg      <= vv_next;
        sa_reg      <= sa_next;
        t1_reg      <= t1_next;
        div_q_reg   <= div_q_next;
        div_r_reg   <= div_r_next;
        div_d_reg   <= div_d_next;
        div_cnt_reg <= div_cnt_next;
        div_tag_reg <= div_tag_next;
        sq_x_reg    <= sq_x_next;
        sq_r_reg    <= sq_r_next;
        sq_bit_reg  <= sq_bit_next;
    end

    always_comb begin
        logic               go_post;
        logic               post_q;
        logic signed [31:0] post_md;
        logic signed [32:0] md_ext;
        logic [32:0]        md_abs;
        logic [30:0]        lim_v;
        logic [30:0]        lim_a;
        logic signed [32:0] delta;
        logic [32:0]        stroke;
        logic signed [35:0] adt;
        logic signed [35:0] travel;
        logic signed [35:0] remaining;
        logic signed [35:0] cv;
        logic signed [35:0] accv;
        logic signed [35:0] vcur;
        logic signed [35:0] v1;
        logic signed [35:0] ramp_s;
        logic [31:0]        vabs;
        logic signed [33:0] mag;
        logic signed [33:0] step;
        logic signed [33:0] p1;
        logic signed [33:0] fin;
        logic [32:0]        rem_sh;
        logic [33:0]        diff;
        logic               ge;
        logic [49:0]        tsum;
        logic [31:0]        tval;
        logic               tdone;
        logic [63:0]        sq_sum;
        logic [63:0]        r_new;

        go_post   = 1'b0;
        post_q    = (state_reg == tmp_pkg::ST_IDLE) ? s_query_time : query_reg;
        post_md   = (state_reg == tmp_pkg::ST_IDLE) ? s_move_delta : md_reg;
        md_ext    = {post_md[31], post_md};
        md_abs    = md_ext[32] ? 33'(-md_ext) : 33'(md_ext);
        lim_v     = '0;
        lim_a     = '0;
        delta     = '0;
        stroke    = '0;
        adt       = '0;
        travel    = '0;
        remaining = '0;
        cv        = '0;
        accv      = '0;
        vcur      = '0;
        v1        = '0;
        ramp_s    = '0;
        vabs      = '0;
        mag       = '0;
        step      = '0;
        p1        = '0;
        fin       = '0;
        rem_sh    = '0;
        diff      = '0;
        ge        = 1'b0;
        tsum      = '0;
        tval      = '0;
        tdone     = 1'b0;
        sq_sum    = '0;
        r_new     = '0;

        mul_a = '0;
        mul_b = '0;

        state_next     = state_reg;
        phase_next     = phase_reg;
        start_pos_next = start_pos_reg;
        final_pos_next = final_pos_reg;
        ref_pos_next   = ref_pos_reg;
        ref_vel_next   = ref_vel_reg;
        ref_acc_next   = ref_acc_reg;
        dir_neg_next   = dir_neg_reg;
        active_next    = active_reg;
        tri_next       = tri_reg;
        stroke_next    = stroke_reg;
        cruise_next    = cruise_reg;
        used_acc_next  = used_acc_reg;
        ramp_next      = ramp_reg;
        ptime_next     = ptime_reg;
        est_next       = est_reg;
        query_next     = query_reg;
        md_next        = md_reg;
        act_next       = act_reg;
        is_plan_next   = is_plan_reg;
        w_s_next       = w_s_reg;
        w_v_next       = w_v_reg;
        w_a_next       = w_a_reg;
        prod_next      = prod_reg;
        vv_next        = vv_reg;
        sa_next        = sa_reg;
        t1_next        = t1_reg;
        div_q_next     = div_q_reg;
        div_r_next     = div_r_reg;
        div_d_next     = div_d_reg;
        div_cnt_next   = div_cnt_reg;
        div_tag_next   = div_tag_reg;
        sq_x_next      = sq_x_reg;
        sq_r_next      = sq_r_reg;
        sq_bit_next    = sq_bit_reg;

        case (state_reg)
            tmp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    query_next = s_query_time;
                    md_next    = s_move_delta;
                    case (tmp_pkg::req_t'(s_req_type))
                        tmp_pkg::REQ_TICK: begin
                            if (!active_reg) begin
                                go_post = 1'b1;
                            end else if (phase_reg == tmp_pkg::PH_DONE) begin
                                // Finished move: snap onto the target and end it.
                                ref_pos_next = final_pos_reg;
                                ref_vel_next = '0;
                                ref_acc_next = '0;
                                active_next  = 1'b0;
                                go_post      = 1'b1;
                            end else begin
                                act_next   = s_pos_actual;
                                state_next = tmp_pkg::ST_TICK_ADT;
                            end
                        end
                        tmp_pkg::REQ_SET_DEF, tmp_pkg::REQ_SET_LIM: begin
                            lim_v = (s_req_type == tmp_pkg::REQ_SET_DEF) ? dvel_reg
                                                                        : s_vel_limit;
                            lim_a = (s_req_type == tmp_pkg::REQ_SET_DEF) ? dacc_reg
                                                                        : s_acc_limit;
                            if (lim_v == '0) begin
                                lim_v = 31'd1;
                            end
                            if (lim_a == '0) begin
                                lim_a = 31'd1;
                            end
                            delta  = {s_pos_final[31], s_pos_final}
                                   - {s_pos_start[31], s_pos_start};
                            stroke = delta[32] ? 33'(-delta) : 33'(delta);
                            start_pos_next = s_pos_start;
                            final_pos_next = s_pos_final;
                            ref_pos_next   = s_pos_start;
                            ref_vel_next   = '0;
                            ref_acc_next   = '0;
                            phase_next     = tmp_pkg::PH_ACCEL;
                            dir_neg_next   = delta[32];
                            stroke_next    = stroke;
                            used_acc_next  = lim_a;
                            if (stroke == '0) begin
                                cruise_next = '0;
                                ramp_next   = '0;
                                ptime_next  = '0;
                                active_next = 1'b0;
                                tri_next    = 1'b0;
                                go_post     = 1'b1;
                            end else begin
                                w_s_next     = stroke;
                                w_v_next     = lim_v;
                                w_a_next     = lim_a;
                                is_plan_next = 1'b1;
                                state_next   = tmp_pkg::ST_TIME_VV;
                            end
                        end
                        default: begin
                            // Stop: the reference position holds where it is.
                            active_next  = 1'b0;
                            ref_vel_next = '0;
                            ref_acc_next = '0;
                            phase_next   = tmp_pkg::PH_DONE;
                            go_post      = 1'b1;
                        end
                    endcase
                end
            end

            tmp_pkg::ST_TICK_ADT: begin
                mul_a      = {1'b0, used_acc_reg};
                mul_b      = tick_reg;
                prod_next  = mul_p;
                state_next = tmp_pkg::ST_TICK_VEL;
            end

            tmp_pkg::ST_TICK_VEL: begin
                adt  = signed'({5'b0, prod_reg[62:32]});
                vcur = signed'({{4{ref_vel_reg[31]}}, ref_vel_reg});
                cv   = signed'({5'b0, cruise_reg});
                accv = signed'({5'b0, used_acc_reg});
                ramp_s = signed'({3'b0, ramp_reg});
                if (dir_neg_reg) begin
                    travel = signed'({{4{start_pos_reg[31]}}, start_pos_reg})
                           - signed'({{4{act_reg[31]}}, act_reg});
                end else begin
                    travel = signed'({{4{act_reg[31]}}, act_reg})
                           - signed'({{4{start_pos_reg[31]}}, start_pos_reg});
                end
                remaining = signed'({3'b0, stroke_reg}) - travel;
                case (phase_reg)
                    tmp_pkg::PH_ACCEL: begin
                        v1 = dir_neg_reg ? vcur - adt : vcur + adt;
                        if (!dir_neg_reg && v1 > cv) begin
                            v1 = cv;
                        end
                        if (dir_neg_reg && v1 < -cv) begin
                            v1 = -cv;
                        end
                        ref_acc_next = dir_neg_reg ? 32'(-accv) : 32'(accv);
                        if (travel >= ramp_s) begin
                            v1         = dir_neg_reg ? -cv : cv;
                            phase_next = tmp_pkg::PH_CRUISE;
                        end
                    end
                    tmp_pkg::PH_CRUISE: begin
                        v1           = dir_neg_reg ? -cv : cv;
                        ref_acc_next = '0;
                        if (remaining <= ramp_s) begin
                            phase_next = tmp_pkg::PH_DECEL;
                        end
                    end
                    tmp_pkg::PH_DECEL: begin
                        v1 = dir_neg_reg ? vcur + adt : vcur - adt;
                        ref_acc_next = dir_neg_reg ? 32'(accv) : 32'(-accv);
                        if (!dir_neg_reg && v1 < 0) begin
                            v1 = '0;
                        end
                        if (dir_neg_reg && v1 > 0) begin
                            v1 = '0;
                        end
                        if (remaining <= 0 || v1 == 0) begin
                            phase_next = tmp_pkg::PH_DONE;
                        end
                    end
                    default: begin
                        v1 = vcur;
                    end
                endcase
                if (v1 > 36'sd2147483647) begin
                    ref_vel_next = 32'sh7FFF_FFFF;
                end else if (v1 < -36'sd2147483648) begin
                    ref_vel_next = 32'sh8000_0000;
                end else begin
                    ref_vel_next = v1[31:0];
                end
                state_next = tmp_pkg::ST_TICK_MAG;
            end

            tmp_pkg::ST_TICK_MAG: begin
                vabs       = ref_vel_reg[31] ? 32'(-ref_vel_reg) : 32'(ref_vel_reg);
                mul_a      = vabs;
                mul_b      = tick_reg;
                prod_next  = mul_p;
                state_next = tmp_pkg::ST_TICK_POS;
            end

            tmp_pkg::ST_TICK_POS: begin
                mag  = signed'({2'b0, prod_reg[63:32]});
                step = ref_vel_reg[31] ? -mag : mag;
                p1   = signed'({{2{ref_pos_reg[31]}}, ref_pos_reg}) + step;
                if (p1 > 34'sd2147483647) begin
                    p1 = 34'sd2147483647;
                end else if (p1 < -34'sd2147483648) begin
                    p1 = -34'sd2147483648;
                end
                fin = signed'({{2{final_pos_reg[31]}}, final_pos_reg});
                if (!dir_neg_reg && p1 > fin) begin
                    p1 = fin;
                end
                if (dir_neg_reg && p1 < fin) begin
                    p1 = fin;
                end
                ref_pos_next = p1[31:0];
                go_post      = 1'b1;
            end

            tmp_pkg::ST_TIME_VV: begin
                mul_a      = {1'b0, w_v_reg};
                mul_b      = {1'b0, w_v_reg};
                prod_next  = mul_p;
                state_next = tmp_pkg::ST_TIME_SA;
            end

            tmp_pkg::ST_TIME_SA: begin
                vv_next    = prod_reg[61:0];
                mul_a      = w_s_reg[31:0];
                mul_b      = {1'b0, w_a_reg};
                prod_next  = mul_p;
                state_next = tmp_pkg::ST_TIME_CMP;
            end

            tmp_pkg::ST_TIME_CMP: begin
                // The stroke's top bit adds A * 2^32 to the partial product.
                sa_next    = prod_reg + (w_s_reg[32] ? 64'({w_a_reg, 32'h0}) : 64'h0);
                state_next = tmp_pkg::ST_TIME_SEL;
            end

            tmp_pkg::ST_TIME_SEL: begin
                if ({2'b0, vv_reg} <= sa_reg) begin
                    // Trapezoid: the velocity limit is reachable.
                    div_r_next   = '0;
                    div_cnt_next = '0;
                    state_next   = tmp_pkg::ST_DIV;
                    if (is_plan_reg) begin
                        tri_next     = 1'b0;
                        cruise_next  = w_v_reg;
                        div_q_next   = {2'b0, vv_reg};
                        div_d_next   = {w_a_reg, 1'b0};
                        div_tag_next = tmp_pkg::DV_RAMP;
                    end else begin
                        div_q_next   = {17'b0, w_v_reg, 16'b0};
                        div_d_next   = {1'b0, w_a_reg};
                        div_tag_next = tmp_pkg::DV_VA;
                    end
                end else begin
                    if (is_plan_reg) begin
                        tri_next  = 1'b1;
                        ramp_next = {1'b0, w_s_reg[32:1]};
                    end
                    sq_x_next   = sa_reg;
                    sq_r_next   = '0;
                    sq_bit_next = 64'h4000_0000_0000_0000;
                    state_next  = tmp_pkg::ST_SQRT;
                end
            end

            tmp_pkg::ST_SQRT: begin
                sq_sum = sq_r_reg + sq_bit_reg;
                if (sq_x_reg >= sq_sum) begin
                    sq_x_next = sq_x_reg - sq_sum;
                    r_new     = (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    r_new     = sq_r_reg >> 1;
                end
                sq_r_next   = r_new;
                sq_bit_next = sq_bit_reg >> 2;
                if (sq_bit_reg[0]) begin
                    if (is_plan_reg) begin
                        cruise_next = r_new[30:0];
                    end
                    div_q_next   = {15'b0, r_new[31:0], 17'b0};
                    div_d_next   = {1'b0, w_a_reg};
                    div_r_next   = '0;
                    div_cnt_next = '0;
                    div_tag_next = tmp_pkg::DV_TRI;
                    state_next   = tmp_pkg::ST_DIV;
                end
            end

            tmp_pkg::ST_DIV: begin
                rem_sh       = {div_r_reg, div_q_reg[63]};
                diff         = {1'b0, rem_sh} - {2'b0, div_d_reg};
                ge           = !diff[33];
                div_r_next   = ge ? diff[31:0] : rem_sh[31:0];
                div_q_next   = {div_q_reg[62:0], ge};
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'd63) begin
                    state_next = tmp_pkg::ST_DIV_DONE;
                end
            end

            tmp_pkg::ST_DIV_DONE: begin
                div_r_next   = '0;
                div_cnt_next = '0;
                case (div_tag_reg)
                    tmp_pkg::DV_RAMP: begin
                        ramp_next    = div_q_reg[32:0];
                        div_q_next   = {17'b0, w_v_reg, 16'b0};
                        div_d_next   = {1'b0, w_a_reg};
                        div_tag_next = tmp_pkg::DV_VA;
                        state_next   = tmp_pkg::ST_DIV;
                    end
                    tmp_pkg::DV_VA: begin
                        t1_next      = div_q_reg[47:0];
                        div_q_next   = {15'b0, w_s_reg, 16'b0};
                        div_d_next   = {1'b0, w_v_reg};
                        div_tag_next = tmp_pkg::DV_SV;
                        state_next   = tmp_pkg::ST_DIV;
                    end
                    tmp_pkg::DV_SV: begin
                        tsum  = {2'b0, t1_reg} + {1'b0, div_q_reg[48:0]};
                        tval  = (tsum[49:32] != '0) ? tmp_pkg::TIME_SAT : tsum[31:0];
                        tdone = 1'b1;
                    end
                    default: begin
                        tval  = (div_q_reg[63:32] != '0) ? tmp_pkg::TIME_SAT
                                                         : div_q_reg[31:0];
                        tdone = 1'b1;
                    end
                endcase
                if (tdone) begin
                    if (is_plan_reg) begin
                        ptime_next  = tval;
                        active_next = 1'b1;
                        go_post     = 1'b1;
                    end else begin
                        est_next   = tval;
                        state_next = tmp_pkg::ST_OUT;
                    end
                end
            end

            tmp_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = tmp_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = tmp_pkg::ST_IDLE;
            end
        endcase

        // After the main action: run the optional time query with the default limits.
        if (go_post) begin
            if (post_q && md_abs != '0) begin
                w_s_next     = md_abs;
                w_v_next     = (dvel_reg == '0) ? 31'd1 : dvel_reg;
                w_a_next     = (dacc_reg == '0) ? 31'd1 : dacc_reg;
                is_plan_next = 1'b0;
                state_next   = tmp_pkg::ST_TIME_VV;
            end else begin
                est_next   = '0;
                state_next = tmp_pkg::ST_OUT;
            end
        end
    end

endmodule

FILE: hdl/tmp_checker.sv
module tmp_assert_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_pos_ref,
    input logic signed [31:0] m_vel_ref,
    input logic signed [31:0] m_acc_ref,
    input logic               m_moving
);

    // One request at a time: never ready for input while a result is shown.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // An accepted request keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("block ready again right after acceptance");

    // A stalled result holds its payload.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pos_ref) && $stable(m_vel_ref)))
        else $error("stalled result changed");

    // With no move in progress the reference is at rest.
    a_rest_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_moving) |-> (m_vel_ref == 32'sd0 && m_acc_ref == 32'sd0))
        else $error("reference moving without an active move");

endmodule

bind trapezoid_motion_profile tmp_assert_checker u_tmp_assert_checker (.*);
